/* rtl/dh_pkg.sv */
package dh_pkg;

    localparam int MOD_BITS_DEFAULT = 32;
    localparam int FIELD_W = 32;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_MODULUS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GENERATOR = 1'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_RED_WAIT,
        ST_LOOP,
        ST_MUL_WAIT,
        ST_FINISH,
        ST_OUTPUT
    } dh_state_t;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } dh_mul_ctrl_t;

endpackage

/* rtl/diffie_hellman_key_exchange_core.sv */
// channel  direction  handshake                 payload
// s_       in         s_tvalid/s_tready         tdata: secret_a, secret_b
// m_       out        m_tvalid/m_tready         tdata: public_a, public_b, shared_a, shared_b, agree
// cfg_     in         cfg_valid/cfg_ready       cfg_index, cfg_data
// one item runs four exponentiations on a shared shift-and-add modular multiplier
// MW = min(MOD_BITS, 32); the multiplier works on MW-bit operands
// each exponentiation: optional base reduction on the multiplier, up to 63 multiplies
// not ready for input or configuration from acceptance until the result transaction completes
// aresetn is synchronous; modulus resets to 13 and generator to 4
module diffie_hellman_key_exchange_core
    import dh_pkg::*;
#(
    parameter int MOD_BITS = MOD_BITS_DEFAULT
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [2*FIELD_W-1:0]    s_tdata,   // secret_a, secret_b
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // public_a, public_b, shared_from_a, shared_from_b, keys_agree
    output logic [4*FIELD_W+7:0]    m_tdata,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [FIELD_W-1:0]      cfg_data
);

    localparam int MW = (MOD_BITS < FIELD_W) ? MOD_BITS : FIELD_W;

    dh_state_t state_reg, state_next;
    logic [MW-1:0] mod_reg, gen_reg;
    logic [FIELD_W-1:0] xa_reg, xb_reg;
    logic [MW-1:0] acc_reg, acc_next;
    logic [MW-1:0] sq_reg, sq_next;
    logic [FIELD_W-1:0] exp_reg, exp_next;
    logic [1:0] phase_reg, phase_next;
    logic [MW-1:0] pub_a_reg, pub_b_reg, ka_reg, kb_reg;
    logic mul_sel_reg, mul_sel_next;
    logic mul_start;
    logic [MW-1:0] mul_a, mul_b, mul_p, base;
    dh_mul_ctrl_t mul_ctrl;
    logic [FIELD_W-1:0] cur_exp;
    logic [MW-1:0] fin_val;

    dh_modmul #(.MOD_BITS(MW)) u_mul (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start),
        .a_in(mul_a), .b_in(mul_b), .m_in(mod_reg),
        .ctrl(mul_ctrl), .product(mul_p)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUTPUT);
    assign cfg_ready = (state_reg == ST_IDLE);

    always_comb begin
        unique case (phase_reg)
            2'd0: begin base = gen_reg; cur_exp = xa_reg; end
            2'd1: begin base = gen_reg; cur_exp = xb_reg; end
            2'd2: begin base = pub_b_reg; cur_exp = xa_reg; end
            default: begin base = pub_a_reg; cur_exp = xb_reg; end
        endcase
    end

    // base reduction runs on the multiplier as 1 * base mod p
    assign fin_val = (exp_reg != '0 && sq_reg == '0) ? '0 : acc_reg;
    assign mul_a = (state_reg == ST_REDUCE) ? MW'(1) : (exp_reg[0] ? acc_reg : sq_reg);
    assign mul_b = (state_reg == ST_REDUCE) ? base : sq_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_tvalid) state_next = (mod_reg < MW'(2)) ? ST_OUTPUT : ST_REDUCE;
            ST_REDUCE: state_next = (base >= mod_reg) ? ST_RED_WAIT : ST_LOOP;
            ST_RED_WAIT: if (mul_ctrl.done) state_next = ST_LOOP;
            ST_LOOP:   state_next = (exp_reg != '0 && sq_reg > MW'(1)) ? ST_MUL_WAIT : ST_FINISH;
            ST_MUL_WAIT: if (mul_ctrl.done) state_next = ST_LOOP;
            ST_FINISH: state_next = (phase_reg == 2'd3) ? ST_OUTPUT : ST_REDUCE;
            ST_OUTPUT: if (m_tready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        acc_next = acc_reg;
        sq_next = sq_reg;
        exp_next = exp_reg;
        phase_next = phase_reg;
        mul_sel_next = mul_sel_reg;
        mul_start = 1'b0;
        unique case (state_reg)
            ST_IDLE: phase_next = 2'd0;
            ST_REDUCE: begin
                acc_next = MW'(1);
                exp_next = cur_exp;
                if (base >= mod_reg) begin
                    mul_start = 1'b1;
                end else begin
                    sq_next = base;
                end
            end
            ST_RED_WAIT: begin
                if (mul_ctrl.done) sq_next = mul_p;
            end
            ST_LOOP: begin
                if (exp_reg != '0 && sq_reg > MW'(1)) begin
                    mul_start = 1'b1;
                    mul_sel_next = exp_reg[0];
                end
            end
            ST_MUL_WAIT: begin
                if (mul_ctrl.done) begin
                    if (mul_sel_reg) begin
                        acc_next = mul_p;
                        exp_next = exp_reg - 1'b1;
                    end else begin
                        sq_next = mul_p;
                        exp_next = exp_reg >> 1;
                    end
                end
            end
            ST_FINISH: phase_next = phase_reg + 2'd1;
            ST_OUTPUT: ;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        sq_reg <= sq_next;
        exp_reg <= exp_next;
        mul_sel_reg <= mul_sel_next;
        if (state_reg == ST_IDLE && s_tvalid) begin
            xa_reg <= s_tdata[FIELD_W-1:0];
            xb_reg <= s_tdata[2*FIELD_W-1:FIELD_W];
            if (mod_reg < MW'(2)) begin
                pub_a_reg <= '0;
                pub_b_reg <= '0;
                ka_reg <= '0;
                kb_reg <= '0;
            end
        end
        if (state_reg == ST_FINISH) begin
            unique case (phase_reg)
                2'd0: pub_a_reg <= fin_val;
                2'd1: pub_b_reg <= fin_val;
                2'd2: ka_reg <= fin_val;
                default: kb_reg <= fin_val;
            endcase
        end
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            phase_reg <= 2'd0;
            mod_reg <= MW'(13);
            gen_reg <= MW'(4);
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_MODULUS:   mod_reg <= cfg_data[MW-1:0];
                    REG_GENERATOR: gen_reg <= cfg_data[MW-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        m_tdata = '0;
        m_tdata[FIELD_W-1:0] = FIELD_W'(pub_a_reg);
        m_tdata[2*FIELD_W-1:FIELD_W] = FIELD_W'(pub_b_reg);
        m_tdata[3*FIELD_W-1:2*FIELD_W] = FIELD_W'(ka_reg);
        m_tdata[4*FIELD_W-1:3*FIELD_W] = FIELD_W'(kb_reg);
        m_tdata[4*FIELD_W] = (ka_reg == kb_reg);
    end

`ifndef SYNTHESIS
    a_no_ready_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_tready) else $error("ready while busy");
    a_out_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid) else $error("result dropped");
    a_wait_mul_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL_WAIT || state_reg == ST_RED_WAIT)
            |-> (mul_ctrl.busy || mul_ctrl.done))
        else $error("multiplier idle while waited on");
`endif

endmodule

/* rtl/dh_modmul.sv */
module dh_modmul
    import dh_pkg::*;
#(
    parameter int MOD_BITS = MOD_BITS_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [MOD_BITS-1:0] a_in,
    input  logic [MOD_BITS-1:0] b_in,
    input  logic [MOD_BITS-1:0] m_in,
    output dh_mul_ctrl_t        ctrl,
    output logic [MOD_BITS-1:0] product
);

    logic [MOD_BITS-1:0] a_reg, a_next;
    logic [MOD_BITS-1:0] b_reg, b_next;
    logic [MOD_BITS-1:0] r_reg, r_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;

    function automatic logic [MOD_BITS-1:0] add_mod(
        input logic [MOD_BITS-1:0] x,
        input logic [MOD_BITS-1:0] y,
        input logic [MOD_BITS-1:0] m
    );
        logic [MOD_BITS-1:0] room;
        room = m - y;
        return (x >= room) ? (x - room) : (x + y);
    endfunction

    always_comb begin
        a_next = a_reg;
        b_next = b_reg;
        r_next = r_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            a_next = a_in;
            b_next = b_in;
            r_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (b_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                if (b_reg[0]) begin
                    r_next = add_mod(r_reg, a_reg, m_in);
                end
                a_next = add_mod(a_reg, a_reg, m_in);
                b_next = b_reg >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        a_reg <= a_next;
        b_reg <= b_next;
        r_reg <= r_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign ctrl.start = start;
    assign ctrl.busy = busy_reg;
    assign ctrl.done = done_reg;
    assign product = r_reg;

`ifndef SYNTHESIS
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg)) else $error("done without busy");
    a_done_clears_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg) else $error("busy after done");
    a_result_below_mod: assert property (@(posedge aclk) disable iff (!aresetn)
        (done_reg && m_in != '0) |-> (r_reg < m_in)) else $error("product not reduced");
`endif

endmodule
